### rtl/ibs_pkg.sv
// Shared constants, types and width helpers for the image box subsample unit.
// Used by every module under rtl; depends on nothing else.
package ibs_pkg;

   // field and register widths
   localparam int PIXEL_W     = 8;
   localparam int FACTOR_W    = 5;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // parameter defaults for the top level
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_FACTOR = 16;

   // largest values the register fields can carry
   localparam int PIXEL_MAX    = 2**PIXEL_W - 1;
   localparam int FACTOR_LIMIT = 2**FACTOR_W - 1;
   localparam int WIDTH_LIMIT  = 2**WIDTH_W - 1;

   // register values after reset
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FACTOR = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } csr_reg_type;

   // position flags that travel with a block mean
   typedef struct packed {
      logic end_of_frame;
      logic end_of_row;
   } flags_type;

   // largest block side the hardware ever sees
   function automatic int max_block(int max_factor);
      return (max_factor < FACTOR_LIMIT) ? max_factor : FACTOR_LIMIT;
   endfunction

   // block sum: up to PIXEL_MAX * f * f
   function automatic int sum_width(int max_factor);
      int m;
      m = max_block(max_factor);
      return $clog2(PIXEL_MAX * m * m + 1);
   endfunction

   // rounding numerator 2*sum + n
   function automatic int num_width(int max_factor);
      int m;
      m = max_block(max_factor);
      return $clog2((2 * PIXEL_MAX + 1) * m * m + 1);
   endfunction

   // divisor 2*n
   function automatic int den_width(int max_factor);
      int m;
      m = max_block(max_factor);
      return $clog2(2 * m * m + 1);
   endfunction

endpackage

### rtl/ibs_accum.sv
// Raster position tracking, configuration registers and the column
// accumulator memory with read-modify-write. Depends on ibs_pkg.
module ibs_accum #(
   parameter int MAX_WIDTH  = ibs_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_FACTOR = ibs_pkg::DEFAULT_MAX_FACTOR
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    enable,
   input  logic                                    pixel_valid,
   input  logic [ibs_pkg::PIXEL_W-1:0]             pixel,
   input  logic                                    csr_write,
   input  logic [ibs_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [ibs_pkg::CSR_DATA_W-1:0]          csr_data,
   output logic                                    dreq_valid,
   output logic [ibs_pkg::num_width(MAX_FACTOR)-1:0] dreq_num,
   output logic [ibs_pkg::den_width(MAX_FACTOR)-1:0] dreq_den,
   output ibs_pkg::flags_type                      dreq_flags
);

   localparam int FW      = ibs_pkg::FACTOR_W;
   localparam int FMAX    = ibs_pkg::max_block(MAX_FACTOR);
   localparam int WMAX    = (MAX_WIDTH < ibs_pkg::WIDTH_LIMIT) ? MAX_WIDTH
                                                               : ibs_pkg::WIDTH_LIMIT;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int CEND_W  = $clog2(MAX_WIDTH + 2 * FMAX + 1);
   localparam int REND_W  = ibs_pkg::HEIGHT_W + 1;
   localparam int SUM_W   = ibs_pkg::sum_width(MAX_FACTOR);
   localparam int NUM_W   = ibs_pkg::num_width(MAX_FACTOR);
   localparam int DEN_W   = ibs_pkg::den_width(MAX_FACTOR);

   // configuration registers
   logic [FW-1:0]                     factor_ff;
   logic [ibs_pkg::WIDTH_W-1:0]       width_ff;
   logic [ibs_pkg::HEIGHT_W-1:0]      height_ff;
   logic                              restart;

   // raster position
   logic [ADDR_W-1:0]                 col_ff, col_in;
   logic [ADDR_W-1:0]                 ocol_ff, ocol_in;
   logic [CEND_W-1:0]                 cstart_ff, cstart_in;
   logic [FW-1:0]                     cph_ff, cph_in;
   logic [ibs_pkg::HEIGHT_W-1:0]      row_ff, row_in;
   logic [REND_W-1:0]                 rstart_ff, rstart_in;
   logic [FW-1:0]                     rph_ff, rph_in;

   // effective settings
   logic [FW-1:0]                     fac;
   logic [ibs_pkg::WIDTH_W-1:0]       w_eff;
   logic [ibs_pkg::HEIGHT_W-1:0]      h_eff;
   logic [2*FW-1:0]                   n_sq;

   // beat decode
   logic                              fire;
   logic                              col_ok, row_ok, active;
   logic                              blk_first, blk_last, eor, eof_band;
   logic [FW:0]                       cph_inc, rph_inc;
   logic [ADDR_W:0]                   col_inc;
   logic [ADDR_W:0]                   w_cmp;
   logic [ibs_pkg::HEIGHT_W:0]        row_inc;

   // update stage
   logic                              b_valid_ff;
   logic                              b_first_ff;
   logic                              b_last_ff;
   logic [ADDR_W-1:0]                 b_addr_ff;
   logic [ibs_pkg::PIXEL_W-1:0]       b_pix_ff;
   ibs_pkg::flags_type                b_flags_ff;
   logic [SUM_W-1:0]                  rdata_ff;
   logic                              wb_valid_ff;
   logic [ADDR_W-1:0]                 wb_addr_ff;
   logic [SUM_W-1:0]                  wb_data_ff;
   logic [SUM_W-1:0]                  base;
   logic [SUM_W-1:0]                  sum;

   // divide request
   logic                              dreq_valid_ff;
   logic [NUM_W-1:0]                  dreq_num_ff;
   logic [DEN_W-1:0]                  dreq_den_ff;
   ibs_pkg::flags_type                dreq_flags_ff;

   logic [SUM_W-1:0]                  mem [MAX_WIDTH];

   // register writes; any known index restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= ibs_pkg::FACTOR_RESET;
         width_ff  <= ibs_pkg::WIDTH_RESET;
         height_ff <= ibs_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (ibs_pkg::csr_reg_type'(csr_index))
            ibs_pkg::REG_FACTOR: factor_ff <= csr_data[FW-1:0];
            ibs_pkg::REG_WIDTH:  width_ff  <= csr_data[ibs_pkg::WIDTH_W-1:0];
            ibs_pkg::REG_HEIGHT: height_ff <= csr_data[ibs_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ibs_pkg::csr_reg_type'(csr_index))
         ibs_pkg::REG_FACTOR,
         ibs_pkg::REG_WIDTH,
         ibs_pkg::REG_HEIGHT: restart = csr_write;
         default:             restart = 1'b0;
      endcase
   end

   // zero means one, too large saturates
   always_comb begin
      if (factor_ff == '0)                    fac = FW'(1);
      else if (factor_ff > FW'(FMAX))         fac = FW'(FMAX);
      else                                    fac = factor_ff;
      if (width_ff == '0)                     w_eff = ibs_pkg::WIDTH_W'(1);
      else if (width_ff > ibs_pkg::WIDTH_W'(WMAX)) w_eff = ibs_pkg::WIDTH_W'(WMAX);
      else                                    w_eff = width_ff;
      h_eff = (height_ff == '0) ? ibs_pkg::HEIGHT_W'(1) : height_ff;
      n_sq  = fac * fac;
   end

   // block membership of the current pixel
   always_comb begin
      fire      = pixel_valid && enable;
      col_ok    = (cstart_ff + CEND_W'(fac)) <= CEND_W'(w_eff);
      eor       = (cstart_ff + CEND_W'({fac, 1'b0})) > CEND_W'(w_eff);
      row_ok    = (rstart_ff + REND_W'(fac)) <= REND_W'(h_eff);
      eof_band  = (rstart_ff + REND_W'({fac, 1'b0})) > REND_W'(h_eff);
      active    = col_ok && row_ok;
      blk_first = (rph_ff == '0) && (cph_ff == '0);
      blk_last  = (rph_ff == fac - FW'(1)) && (cph_ff == fac - FW'(1));
   end

   // next raster position
   always_comb begin
      cph_inc   = {1'b0, cph_ff} + (FW+1)'(1);
      rph_inc   = {1'b0, rph_ff} + (FW+1)'(1);
      col_inc   = {1'b0, col_ff} + (ADDR_W+1)'(1);
      w_cmp     = (ADDR_W+1)'(w_eff);
      row_inc   = {1'b0, row_ff} + (ibs_pkg::HEIGHT_W+1)'(1);
      col_in    = col_inc[ADDR_W-1:0];
      cph_in    = cph_inc[FW-1:0];
      ocol_in   = ocol_ff;
      cstart_in = cstart_ff;
      row_in    = row_ff;
      rph_in    = rph_ff;
      rstart_in = rstart_ff;
      if (cph_inc >= {1'b0, fac}) begin
         cph_in    = '0;
         ocol_in   = ocol_ff + ADDR_W'(1);
         cstart_in = cstart_ff + CEND_W'(fac);
      end
      if (col_inc >= w_cmp) begin
         col_in    = '0;
         cph_in    = '0;
         ocol_in   = '0;
         cstart_in = '0;
         row_in    = row_inc[ibs_pkg::HEIGHT_W-1:0];
         rph_in    = rph_inc[FW-1:0];
         if (rph_inc >= {1'b0, fac}) begin
            rph_in    = '0;
            rstart_in = rstart_ff + REND_W'(fac);
         end
         if (row_inc >= {1'b0, h_eff}) begin
            row_in    = '0;
            rph_in    = '0;
            rstart_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff    <= '0;
         ocol_ff   <= '0;
         cstart_ff <= '0;
         cph_ff    <= '0;
         row_ff    <= '0;
         rstart_ff <= '0;
         rph_ff    <= '0;
      end else if (fire) begin
         col_ff    <= col_in;
         ocol_ff   <= ocol_in;
         cstart_ff <= cstart_in;
         cph_ff    <= cph_in;
         row_ff    <= row_in;
         rstart_ff <= rstart_in;
         rph_ff    <= rph_in;
      end
   end

   // accepted beat moves into the update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= fire && active;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         b_first_ff            <= blk_first;
         b_last_ff             <= blk_last;
         b_addr_ff             <= ocol_ff;
         b_pix_ff              <= pixel;
         b_flags_ff.end_of_row   <= eor;
         b_flags_ff.end_of_frame <= eor && eof_band;
      end
   end

   // accumulator memory: read on accept, write back one stage later
   always_ff @(posedge clock) begin
      if (fire) begin
         rdata_ff <= mem[ocol_ff];
      end
      if (enable && b_valid_ff) begin
         mem[b_addr_ff] <= sum;
      end
   end

   // last write, forwarded to a beat that read the same column too early
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (enable && b_valid_ff) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && b_valid_ff) begin
         wb_addr_ff <= b_addr_ff;
         wb_data_ff <= sum;
      end
   end

   always_comb begin
      if (b_first_ff)                                   base = '0;
      else if (wb_valid_ff && (wb_addr_ff == b_addr_ff)) base = wb_data_ff;
      else                                              base = rdata_ff;
      sum = base + SUM_W'(b_pix_ff);
   end

   // completed block goes to the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         dreq_valid_ff <= 1'b0;
      end else if (enable) begin
         dreq_valid_ff <= b_valid_ff && b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && b_valid_ff && b_last_ff) begin
         dreq_num_ff   <= NUM_W'({sum, 1'b0}) + NUM_W'(n_sq);
         dreq_den_ff   <= DEN_W'({n_sq, 1'b0});
         dreq_flags_ff <= b_flags_ff;
      end
   end

   assign dreq_valid = dreq_valid_ff;
   assign dreq_num   = dreq_num_ff;
   assign dreq_den   = dreq_den_ff;
   assign dreq_flags = dreq_flags_ff;

endmodule

### rtl/ibs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, giving the
// rounded block mean. Depends on ibs_pkg.
module ibs_divider #(
   parameter int MAX_FACTOR = ibs_pkg::DEFAULT_MAX_FACTOR
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      enable,
   input  logic                                      in_valid,
   input  logic [ibs_pkg::num_width(MAX_FACTOR)-1:0] in_num,
   input  logic [ibs_pkg::den_width(MAX_FACTOR)-1:0] in_den,
   input  ibs_pkg::flags_type                        in_flags,
   output logic                                      out_valid,
   output logic [ibs_pkg::PIXEL_W-1:0]               out_mean,
   output ibs_pkg::flags_type                        out_flags
);

   localparam int QW    = ibs_pkg::PIXEL_W;
   localparam int NUM_W = ibs_pkg::num_width(MAX_FACTOR);
   localparam int DEN_W = ibs_pkg::den_width(MAX_FACTOR);
   localparam int DIV_W = DEN_W + QW;

   // stage inputs; stage 0 is the request itself
   logic [DIV_W-1:0]   rem_w   [QW];
   logic [DEN_W-1:0]   den_w   [QW];
   logic [QW-1:0]      q_w     [QW];
   ibs_pkg::flags_type flags_w [QW];
   logic               valid_w [QW];

   // stage registers between bit steps
   logic [DIV_W-1:0]   rem_ff   [1:QW-1];
   logic [DEN_W-1:0]   den_ff   [1:QW-1];
   logic [QW-1:0]      q_ff     [1:QW-1];
   ibs_pkg::flags_type flags_ff [1:QW-1];
   logic               valid_ff [1:QW-1];

   logic               out_valid_ff;
   logic [QW-1:0]      out_mean_ff;
   ibs_pkg::flags_type out_flags_ff;

   assign rem_w[0]   = DIV_W'(in_num);
   assign den_w[0]   = in_den;
   assign q_w[0]     = '0;
   assign flags_w[0] = in_flags;
   assign valid_w[0] = in_valid;

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      logic [DIV_W-1:0] dsh;
      logic             ge;
      logic [QW-1:0]    q_next;

      // try the divisor at this bit weight
      assign dsh    = DIV_W'(den_w[k]) << SH;
      assign ge     = rem_w[k] >= dsh;
      assign q_next = {q_w[k][QW-2:0], ge};

      if (k < QW - 1) begin : g_mid
         logic [DIV_W-1:0] rem_next;
         assign rem_next = ge ? (rem_w[k] - dsh) : rem_w[k];

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else if (enable) begin
               valid_ff[k+1] <= valid_w[k];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1]   <= rem_next;
               den_ff[k+1]   <= den_w[k];
               q_ff[k+1]     <= q_next;
               flags_ff[k+1] <= flags_w[k];
            end
         end

         assign rem_w[k+1]   = rem_ff[k+1];
         assign den_w[k+1]   = den_ff[k+1];
         assign q_w[k+1]     = q_ff[k+1];
         assign flags_w[k+1] = flags_ff[k+1];
         assign valid_w[k+1] = valid_ff[k+1];
      end else begin : g_last
         // final bit: remainder no longer needed
         always_ff @(posedge clock) begin
            if (reset) begin
               out_valid_ff <= 1'b0;
            end else if (enable) begin
               out_valid_ff <= valid_w[k];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               out_mean_ff  <= q_next;
               out_flags_ff <= flags_w[k];
            end
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_mean  = out_mean_ff;
   assign out_flags = out_flags_ff;

endmodule

### rtl/ibs_skid.sv
// Two-entry output buffer that decouples the result channel from the
// pipeline advance. Depends on ibs_pkg.
module ibs_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [ibs_pkg::PIXEL_W-1:0] push_mean,
   input  ibs_pkg::flags_type          push_flags,
   output logic                        room,
   input  logic                        pop_ready,
   output logic                        out_valid,
   output logic [ibs_pkg::PIXEL_W-1:0] out_mean,
   output ibs_pkg::flags_type          out_flags
);

   logic [1:0]                  count_ff, count_in;
   logic                        wr_ptr_ff;
   logic                        rd_ptr_ff;
   logic                        pop;
   logic [ibs_pkg::PIXEL_W-1:0] mean_ff  [2];
   ibs_pkg::flags_type          flags_ff [2];

   assign pop       = out_valid && pop_ready;
   assign out_valid = count_ff != 2'd0;
   assign room      = count_ff != 2'd2;
   assign out_mean  = mean_ff[rd_ptr_ff];
   assign out_flags = flags_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mean_ff[wr_ptr_ff]  <= push_mean;
         flags_ff[wr_ptr_ff] <= push_flags;
      end
   end

endmodule

### rtl/image_box_subsample_unit.sv
// Box-filter decimation of an 8-bit grayscale raster stream.
//
// req_*: one pixel per beat in raster order. rsp_*: one beat per full
// factor x factor block, carrying the mean rounded half up; tlast marks the
// last block of an output row, tuser the last block of the frame.
// csr_*: register writes (0 factor, 1 frame width, 2 frame height); a write to
// any of these returns the raster position to the start of a frame. Write only
// while no pixel is in flight.
//
// Throughput: one pixel per cycle while the output buffer has room, set by the
// read-modify-write of the column accumulator memory on its separate read and
// write ports (conflicts forwarded). Path: a block mean reaches rsp through
// the update stage, the divide request register, eight divider stages and the
// output buffer; the memory read happens on the accepting edge itself.
// Stalls: a two-entry output buffer holds results; when it is full the whole
// pipeline freezes and req_tready drops until the receiver takes a beat.
// Reset: registers return to factor 1, 1024 x 1024, position counters to the
// frame start; the accumulator memory is not cleared, since every block
// starts by overwriting its column entry.
// Depends on ibs_pkg, ibs_accum, ibs_divider, ibs_skid.
module image_box_subsample_unit #(
   parameter int MAX_WIDTH  = ibs_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_FACTOR = ibs_pkg::DEFAULT_MAX_FACTOR
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] pixel
   // block mean out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] mean_pixel
   output logic                            rsp_tlast,   // end_of_row
   output logic [0:0]                      rsp_tuser,   // [0] end_of_frame
   // register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ibs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ibs_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int NUM_W = ibs_pkg::num_width(MAX_FACTOR);
   localparam int DEN_W = ibs_pkg::den_width(MAX_FACTOR);

   logic                        enable;
   logic                        dreq_valid;
   logic [NUM_W-1:0]            dreq_num;
   logic [DEN_W-1:0]            dreq_den;
   ibs_pkg::flags_type          dreq_flags;
   logic                        div_valid;
   logic [ibs_pkg::PIXEL_W-1:0] div_mean;
   ibs_pkg::flags_type          div_flags;
   ibs_pkg::flags_type          out_flags;
   logic                        skid_room;

   // pipeline advances while the output buffer has a free entry
   assign enable     = skid_room;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   ibs_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .pixel_valid (req_tvalid),
      .pixel       (req_tdata),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .dreq_valid  (dreq_valid),
      .dreq_num    (dreq_num),
      .dreq_den    (dreq_den),
      .dreq_flags  (dreq_flags)
   );

   ibs_divider #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (dreq_valid),
      .in_num    (dreq_num),
      .in_den    (dreq_den),
      .in_flags  (dreq_flags),
      .out_valid (div_valid),
      .out_mean  (div_mean),
      .out_flags (div_flags)
   );

   ibs_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (enable && div_valid),
      .push_mean  (div_mean),
      .push_flags (div_flags),
      .room       (skid_room),
      .pop_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_mean   (rsp_tdata),
      .out_flags  (out_flags)
   );

   assign rsp_tlast    = out_flags.end_of_row;
   assign rsp_tuser[0] = out_flags.end_of_frame;

`ifndef NO_ASSERTIONS
   // input only backs up when results are waiting
   a_stall_has_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // the frame ends on the last block of a row
   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("end of frame without end of row");

   // a frozen pipeline keeps its divider result
   a_divider_holds: assert property (@(posedge clock) disable iff (reset)
      div_valid && !enable |=> div_valid && $stable(div_mean) && $stable(div_flags))
      else $error("divider output changed while stalled");
`endif

endmodule

### sim/image_box_subsample_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for image_box_subsample_unit: directed and random pixel frames, every
// block mean checked beat by beat against a box-filter predictor kept in the bench.
// Depends on ibs_pkg and the image_box_subsample_unit RTL.
module image_box_subsample_unit_tb;

   localparam int MAX_W          = ibs_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_F          = ibs_pkg::DEFAULT_MAX_FACTOR;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int RANDOM_PIXELS  = 100;
   localparam int RANDOM_BURST   = 150;
   localparam int IDLE_PERCENT   = 19;
   // index past the last register: the block must ignore it
   localparam logic [ibs_pkg::CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL, PIX_MIXED} pixel_mode_type;

   typedef struct packed {
      logic [ibs_pkg::PIXEL_W-1:0] mean;
      logic                        end_of_row;
      logic                        end_of_frame;
   } block_mean_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;    // [7:0] pixel
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;          // [7:0] mean_pixel
   logic                            rsp_tlast;          // end_of_row
   logic [0:0]                      rsp_tuser;          // [0] end_of_frame
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [ibs_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [ibs_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   bit no_idle       = 1'b0;
   int error_count   = 0;
   int cycle_count   = 0;
   int random_pixels = 0;

   // predictor state: registers, raster position, column sums
   logic [ibs_pkg::FACTOR_W-1:0] cur_factor;
   logic [ibs_pkg::WIDTH_W-1:0]  cur_width;
   logic [ibs_pkg::HEIGHT_W-1:0] cur_height;
   int unsigned                  block_sums [MAX_W];
   int unsigned                  pix_col, pix_row, col_phase, row_phase, block_col;
   block_mean_type               expected_means [$];

   image_box_subsample_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned eff_factor();
      if (cur_factor == 0) return 1;
      if (cur_factor > MAX_F) return MAX_F;
      return cur_factor;
   endfunction

   function automatic int unsigned eff_width();
      if (cur_width == 0) return 1;
      if (cur_width > MAX_W) return MAX_W;
      return cur_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cur_height == 0) ? 1 : cur_height;
   endfunction

   function automatic void restart_raster();
      pix_col   = 0;
      pix_row   = 0;
      col_phase = 0;
      row_phase = 0;
      block_col = 0;
   endfunction

   function automatic void apply_reg(logic [ibs_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [ibs_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         ibs_pkg::REG_FACTOR: cur_factor = val[ibs_pkg::FACTOR_W-1:0];
         ibs_pkg::REG_WIDTH:  cur_width  = val[ibs_pkg::WIDTH_W-1:0];
         ibs_pkg::REG_HEIGHT: cur_height = val[ibs_pkg::HEIGHT_W-1:0];
         default:             return;   // unknown index: no store, no restart
      endcase
      restart_raster();
   endfunction

   // add one pixel to its column sum; queue the mean when a block completes
   function automatic void accumulate_pixel(logic [ibs_pkg::PIXEL_W-1:0] pix);
      int unsigned    f, w, h, ocols, used_rows, s, n;
      block_mean_type res;
      f         = eff_factor();
      w         = eff_width();
      h         = eff_height();
      ocols     = w / f;
      used_rows = (h / f) * f;
      if (block_col < ocols && pix_row < used_rows) begin
         s = (row_phase == 0 && col_phase == 0) ? pix : block_sums[block_col] + pix;
         block_sums[block_col] = s;
         if (row_phase == f - 1 && col_phase == f - 1) begin
            n                = f * f;
            res.mean         = ibs_pkg::PIXEL_W'((2 * s + n) / (2 * n));
            res.end_of_row   = (block_col == ocols - 1);
            res.end_of_frame = res.end_of_row && (pix_row + 1 == used_rows);
            expected_means.push_back(res);
         end
      end
      // advance raster position
      pix_col++;
      col_phase++;
      if (col_phase >= f) begin
         col_phase = 0;
         block_col++;
      end
      if (pix_col >= w) begin
         pix_col   = 0;
         col_phase = 0;
         block_col = 0;
         pix_row++;
         row_phase++;
         if (row_phase >= f) row_phase = 0;
         if (pix_row >= h) begin
            pix_row   = 0;
            row_phase = 0;
         end
      end
   endfunction

   // ---------------------------------------------------------------- drivers
   function automatic logic [7:0] make_pixel(pixel_mode_type mode);
      int r;
      r = $urandom_range(19);
      case (mode)
         PIX_ZERO: return 8'h00;
         PIX_FULL: return 8'hFF;
         PIX_MIXED: begin
            if (r == 0) return 8'h00;
            if (r == 1) return 8'hFF;
            return 8'($urandom_range(255));
         end
         default:  return 8'($urandom_range(255));
      endcase
   endfunction

   // one pixel beat, with random idle cycles in front
   task automatic send_pixel(input logic [7:0] pix);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accumulate_pixel(pix);
   endtask

   task automatic send_pixels(input int n, input pixel_mode_type mode);
      repeat (n) send_pixel(make_pixel(mode));
   endtask

   // register write; bits above the register width are random
   task automatic write_reg(input logic [ibs_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned value);
      logic [ibs_pkg::CSR_DATA_W-1:0] mask, word;
      case (idx)
         ibs_pkg::REG_FACTOR: mask = ibs_pkg::CSR_DATA_W'((1 << ibs_pkg::FACTOR_W) - 1);
         ibs_pkg::REG_WIDTH:  mask = ibs_pkg::CSR_DATA_W'((1 << ibs_pkg::WIDTH_W) - 1);
         ibs_pkg::REG_HEIGHT: mask = ibs_pkg::CSR_DATA_W'((1 << ibs_pkg::HEIGHT_W) - 1);
         default:             mask = '0;
      endcase
      word      = (ibs_pkg::CSR_DATA_W'($urandom) & ~mask)
                | (ibs_pkg::CSR_DATA_W'(value) & mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, word);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned f, input int unsigned w,
                               input int unsigned h);
      write_reg(ibs_pkg::REG_FACTOR, f);
      write_reg(ibs_pkg::REG_WIDTH, w);
      write_reg(ibs_pkg::REG_HEIGHT, h);
   endtask

   // stop sending, wait for every mean, then let trailing pixels drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   // register values after reset: factor 1 over a 1024 wide frame
   task automatic test_reset_defaults();
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      send_pixels(4, PIX_MIXED);
      settle();
   endtask

   // 2x2 block summing to 2 rounds half up to 1; full-scale block stays 255
   task automatic test_rounding();
      set_geometry(2, 4, 2);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      settle();
   endtask

   // zero factor, zero width and zero height all act as 1
   task automatic test_zero_registers();
      set_geometry(0, 3, 1);
      send_pixels(3, PIX_MIXED);
      settle();
      set_geometry(1, 0, 0);
      send_pixels(3, PIX_MIXED);
      settle();
   endtask

   // factor larger than width or height: no block ever completes
   task automatic test_no_fit();
      set_geometry(5, 4, 8);
      send_pixels(16, PIX_RANDOM);
      settle();
      set_geometry(3, 8, 2);
      send_pixels(16, PIX_RANDOM);
      settle();
   endtask

   // largest block, and a factor above the limit saturating to it
   task automatic test_large_factor();
      set_geometry(MAX_F, 16, 16);
      send_pixels(256, PIX_FULL);
      settle();
      set_geometry(31, 17, 16);
      send_pixels(272, PIX_RANDOM);
      settle();
   endtask

   // right columns and bottom row dropped, two frames back to back
   task automatic test_crop();
      set_geometry(3, 8, 7);
      send_pixels(112, PIX_MIXED);
      settle();
   endtask

   // width above the limit saturates; full-rate stretch with no idling
   task automatic test_wide_row();
      no_idle = 1'b1;
      set_geometry(1, 2047, 1);
      send_pixels(MAX_W, PIX_RANDOM);
      settle();
      no_idle = 1'b0;
   endtask

   // tallest frame: no end of frame within the rows sent
   task automatic test_tall_frame();
      set_geometry(1, 2, 16383);
      send_pixels(40, PIX_MIXED);
      settle();
   endtask

   // write to an unused index mid-frame must not restart the raster
   task automatic test_spare_index();
      set_geometry(2, 6, 4);
      send_pixels(8, PIX_MIXED);
      settle();
      write_reg(REG_SPARE, 0);
      send_pixels(16, PIX_MIXED);
      settle();
   endtask

   // random geometries: mostly whole frames, some cut short by a rewrite
   task automatic test_random_frames();
      int unsigned vals [3];
      int unsigned frame, n, start, f;
      logic [ibs_pkg::CSR_INDEX_W-1:0] idx;
      set_geometry(2, 10, 6);
      while (random_pixels < RANDOM_PIXELS) begin
         n = $urandom_range(99);
         if (n < 80)      f = $urandom_range(1, 4);
         else if (n < 92) f = $urandom_range(5, MAX_F);
         else             f = ($urandom_range(1) == 0) ? 0 : $urandom_range(17, 31);
         vals[ibs_pkg::REG_FACTOR] = f;
         vals[ibs_pkg::REG_WIDTH]  = ($urandom_range(29) == 0) ? 0 : $urandom_range(1, 40);
         vals[ibs_pkg::REG_HEIGHT] = ($urandom_range(29) == 0) ? 0 : $urandom_range(1, 16);
         if ($urandom_range(3) == 0) begin
            idx = ibs_pkg::CSR_INDEX_W'($urandom_range(2));
            write_reg(idx, vals[idx]);
         end else begin
            start = $urandom_range(2);
            for (int k = 0; k < 3; k++) begin
               idx = ibs_pkg::CSR_INDEX_W'((start + k) % 3);
               write_reg(idx, vals[idx]);
            end
         end
         frame = eff_width() * eff_height();
         if ($urandom_range(3) != 0) n = frame * $urandom_range(1, 2);
         else                        n = $urandom_range(1, frame + frame / 2);
         if (n > RANDOM_BURST) n = RANDOM_BURST;
         send_pixels(n, PIX_MIXED);
         random_pixels += n;
         settle();
      end
   endtask

   // ---------------------------------------------------------------- result check
   always @(posedge clock) begin : rsp_check
      block_mean_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $display("%0t: unexpected beat: mean %0d, end_of_row %0b, end_of_frame %0b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser[0]);
               error_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_tdata !== want.mean) begin
                  $display("%0t: mean_pixel expected %0d, got %0d",
                           $time, want.mean, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.end_of_row) begin
                  $display("%0t: end_of_row expected %0b, got %0b",
                           $time, want.end_of_row, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.end_of_frame) begin
                  $display("%0t: end_of_frame expected %0b, got %0b",
                           $time, want.end_of_frame, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d block means outstanding", $time, expected_means.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      cur_factor = ibs_pkg::FACTOR_RESET;
      cur_width  = ibs_pkg::WIDTH_RESET;
      cur_height = ibs_pkg::HEIGHT_RESET;
      restart_raster();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_rounding();
      test_zero_registers();
      test_no_fit();
      test_large_factor();
      test_crop();
      test_wide_row();
      test_tall_frame();
      test_spare_index();
      test_random_frames();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
